@@ rtl/core/image_window_fetch_with_edge_modes_assert.svh @@
// Assertion macros used by the checker module of the window fetch block.
`ifndef IMAGE_WINDOW_FETCH_WITH_EDGE_MODES_ASSERT_SVH
`define IMAGE_WINDOW_FETCH_WITH_EDGE_MODES_ASSERT_SVH

// Property that skips the cycles in reset.
`define IWF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("window fetch assertion failed");

// Property that checks what reset itself leaves behind.
`define IWF_ASSERT_RESET(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("window fetch reset assertion failed");

`endif

@@ rtl/core/iwf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package iwf_pkg;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_FETCH = 1'b1;

  localparam logic [1:0] EDGE_WRAP   = 2'd0;
  localparam logic [1:0] EDGE_BLACK  = 2'd1;
  localparam logic [1:0] EDGE_REPEAT = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;

  localparam logic [2:0] REG_WIDTH   = 3'd0;
  localparam logic [2:0] REG_HEIGHT  = 3'd1;
  localparam logic [2:0] REG_EDGE    = 3'd2;
  localparam logic [2:0] REG_CHANNEL = 3'd3;
  localparam logic [2:0] REG_WINDOW  = 3'd4;

  localparam int CFG_DW = 9;

  typedef struct packed {
    logic [8:0] image_width;
    logic [8:0] image_height;
    logic [1:0] edge_mode;
    logic [1:0] color_channel;
    logic [2:0] window_size;
  } cfg_t;

  // Travels alongside a store read; the read data arrives in the next cycle.
  typedef struct packed {
    logic valid;
    logic black;
    logic last;
  } rd_tag_t;

  function automatic logic [7:0] pick_channel(logic [23:0] rgb, logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      CH_RED:   v = rgb[23:16];
      CH_GREEN: v = rgb[15:8];
      default:  v = rgb[7:0];
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/iwf_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
interface iwf_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  coord_x;
  logic [7:0]  coord_y;
  logic [23:0] pixel_rgb;

  modport source (output valid, action, coord_x, coord_y, pixel_rgb, input ready);
  modport sink (input valid, action, coord_x, coord_y, pixel_rgb, output ready);
endinterface

interface iwf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] channel_value;
  logic       last_of_window;

  modport source (output valid, channel_value, last_of_window, input ready);
  modport sink (input valid, channel_value, last_of_window, output ready);
endinterface
`default_nettype wire

@@ rtl/core/iwf_store.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iwf_store #(
  parameter int AW = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic          re,
  input  wire logic [AW-1:0] addr,
  input  wire logic [23:0]   wdata,
  output logic      [23:0]   rdata
);

  logic [23:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/iwf_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iwf_seq #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 7,
  parameter int XW = 8,
  parameter int YW = 8,
  parameter int CW = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire iwf_pkg::cfg_t        cfg,
  iwf_in_if.sink                    in_ch,
  input  wire logic                 room,
  output logic                      mem_we,
  output logic                      mem_re,
  output logic      [XW+YW-1:0]     mem_addr,
  output logic      [23:0]          mem_wdata,
  output iwf_pkg::rd_tag_t          tag
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                state;
  logic signed [CW-1:0]  xs;
  logic signed [CW-1:0]  ys;
  logic [2:0]            xx;
  logic [2:0]            yy;
  logic [2:0]            size;

  logic signed [CW-1:0]  w_eff, h_eff, iw, ih, cx, cy;
  logic [2:0]            size_eff;
  logic signed [CW-1:0]  px, py;
  logic [CW:0]           rx, ry;
  logic                  accept, issue, last_pix, wr_in;

  function automatic logic [CW:0] resolve(logic signed [CW-1:0] c,
                                          logic signed [CW-1:0] d,
                                          logic [1:0] mode);
    logic signed [CW-1:0] r;
    logic                 blk;
    r = c;
    case (mode)
      iwf_pkg::EDGE_WRAP: begin
        if (c < 0) r = c + d;
        else if (c >= d) r = c - d;
      end
      iwf_pkg::EDGE_REPEAT: begin
        if (c < 0) r = '0;
        else if (c >= d) r = d - CW'(1);
      end
      default: r = c;
    endcase
    blk = (r < 0) || (r >= d);
    return {blk, r};
  endfunction

  always_comb begin
    iw = $signed({{(CW-9){1'b0}}, cfg.image_width});
    ih = $signed({{(CW-9){1'b0}}, cfg.image_height});
    if (cfg.image_width == '0) w_eff = CW'(1);
    else if (iw > $signed(CW'(MAX_WIDTH))) w_eff = CW'(MAX_WIDTH);
    else w_eff = iw;
    if (cfg.image_height == '0) h_eff = CW'(1);
    else if (ih > $signed(CW'(MAX_HEIGHT))) h_eff = CW'(MAX_HEIGHT);
    else h_eff = ih;
    size_eff = (cfg.window_size > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : cfg.window_size;
  end

  assign cx = $signed({{(CW-8){1'b0}}, in_ch.coord_x});
  assign cy = $signed({{(CW-8){1'b0}}, in_ch.coord_y});

  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign wr_in       = accept && (in_ch.action == iwf_pkg::ACT_WRITE) &&
                       (cx < w_eff) && (cy < h_eff);

  assign px = xs + $signed({{(CW-3){1'b0}}, xx});
  assign py = ys + $signed({{(CW-3){1'b0}}, yy});
  assign rx = resolve(px, w_eff, cfg.edge_mode);
  assign ry = resolve(py, h_eff, cfg.edge_mode);

  assign issue    = (state == ST_RUN) && room;
  assign last_pix = (xx == size - 3'd1) && (yy == size - 3'd1);

  always_comb begin
    mem_we    = wr_in;
    mem_re    = issue;
    mem_wdata = in_ch.pixel_rgb;
    if (state == ST_RUN) begin
      mem_addr = {ry[YW-1:0], rx[XW-1:0]};
    end else begin
      mem_addr = {cy[YW-1:0], cx[XW-1:0]};
    end
    tag.valid = issue;
    tag.black = rx[CW] || ry[CW];
    tag.last  = last_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      xx    <= '0;
      yy    <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept && (in_ch.action == iwf_pkg::ACT_FETCH) && (size_eff != '0)) begin
            state <= ST_RUN;
            size  <= size_eff;
            xs    <= cx - $signed({{(CW-3){1'b0}}, size_eff >> 1});
            ys    <= cy - $signed({{(CW-3){1'b0}}, size_eff >> 1});
            xx    <= '0;
            yy    <= '0;
          end
        end
        ST_RUN: begin
          if (issue) begin
            // advance down the column, then to the next column
            if (yy == size - 3'd1) begin
              yy <= '0;
              xx <= xx + 3'd1;
              if (last_pix) begin
                state <= ST_IDLE;
              end
            end else begin
              yy <= yy + 3'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/iwf_outbuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
module iwf_outbuf (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire iwf_pkg::rd_tag_t tag,
  input  wire logic [23:0]      rdata,
  input  wire logic [1:0]       color_channel,
  output logic                  room,
  iwf_out_if.source             out_ch
);

  iwf_pkg::rd_tag_t pend;
  logic             out_valid, skid_valid;
  logic [7:0]       out_value, skid_value;
  logic             out_last, skid_last;
  logic [7:0]       data;
  logic             pop;
  logic [1:0]       occ;

  assign data = pend.black ? 8'd0 : iwf_pkg::pick_channel(rdata, color_channel);
  assign pop  = out_valid && out_ch.ready;
  assign occ  = 2'(out_valid) + 2'(skid_valid) + 2'(pend.valid) - 2'(pop);
  // a read issued now lands next cycle; keep one of the two slots free for it
  assign room = (occ < 2'd2);

  assign out_ch.valid          = out_valid;
  assign out_ch.channel_value  = out_value;
  assign out_ch.last_of_window = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      pend.valid <= tag.valid;
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= pend.valid;
        end else begin
          out_valid  <= pend.valid;
        end
      end else if (pend.valid) begin
        skid_valid <= 1'b1;
      end
    end
    pend.black <= tag.black;
    pend.last  <= tag.last;
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_value  <= skid_value;
        out_last   <= skid_last;
        skid_value <= data;
        skid_last  <= pend.last;
      end else begin
        out_value <= data;
        out_last  <= pend.last;
      end
    end else if (pend.valid) begin
      skid_value <= data;
      skid_last  <= pend.last;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/image_window_fetch_with_edge_modes.sv @@
// Write item: the pixel lands in the frame store at the accepting edge.
// Fetch item: accept, then one store read per window pixel;
// reads hold while the output backs up; each result is registered at the store read and again at the output.
// Input ready returns the cycle after the last window read is issued.
// Reset clears control and restores registers to 256, 256, repeat edge, red, 3;
// the frame store is not cleared and reads as garbage until written.
`timescale 1ns / 1ps
`default_nettype none
module image_window_fetch_with_edge_modes #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [2:0]                 cfg_index,
  input  wire logic [iwf_pkg::CFG_DW-1:0] cfg_data,
  iwf_in_if.sink                          in_ch,
  iwf_out_if.source                       out_ch
);

  localparam int XW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int XDW  = $clog2(MAX_WIDTH + 1);
  localparam int YDW  = $clog2(MAX_HEIGHT + 1);
  localparam int DMAX = (XDW > YDW) ? ((XDW > 9) ? XDW : 9) : ((YDW > 9) ? YDW : 9);
  localparam int CW   = DMAX + 1;
  localparam int AW   = XW + YW;

  iwf_pkg::cfg_t    cfg;
  iwf_pkg::rd_tag_t tag;
  logic             room, mem_we, mem_re;
  logic [AW-1:0]    mem_addr;
  logic [23:0]      mem_wdata, mem_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= 9'd256;
      cfg.image_height  <= 9'd256;
      cfg.edge_mode     <= iwf_pkg::EDGE_REPEAT;
      cfg.color_channel <= iwf_pkg::CH_RED;
      cfg.window_size   <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        iwf_pkg::REG_WIDTH:   cfg.image_width   <= cfg_data[8:0];
        iwf_pkg::REG_HEIGHT:  cfg.image_height  <= cfg_data[8:0];
        iwf_pkg::REG_EDGE:    cfg.edge_mode     <= cfg_data[1:0];
        iwf_pkg::REG_CHANNEL: cfg.color_channel <= cfg_data[1:0];
        iwf_pkg::REG_WINDOW:  cfg.window_size   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  iwf_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW),
    .XW         (XW),
    .YW         (YW),
    .CW         (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_ch     (in_ch),
    .room      (room),
    .mem_we    (mem_we),
    .mem_re    (mem_re),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .tag       (tag)
  );

  iwf_store #(
    .AW (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  iwf_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .tag           (tag),
    .rdata         (mem_rdata),
    .color_channel (cfg.color_channel),
    .room          (room),
    .out_ch        (out_ch)
  );

endmodule
`default_nettype wire

@@ rtl/core/iwf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "image_window_fetch_with_edge_modes_assert.svh"
module iwf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_action,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_value,
  input wire logic       out_last
);

  // out of reset the block is idle with nothing to show
  `IWF_ASSERT_RESET(a_reset_idle, clk, rst, !out_valid && in_ready)
  // a write item never holds off the next item
  `IWF_ASSERT_NEXT(a_write_one_cycle, clk, rst, in_valid && in_ready && (in_action == iwf_pkg::ACT_WRITE), in_ready)
  `IWF_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `IWF_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_value) && $stable(out_last))

endmodule

bind image_window_fetch_with_edge_modes iwf_checker u_iwf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_action (in_ch.action),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_value (out_ch.channel_value),
  .out_last  (out_ch.last_of_window)
);
`default_nettype wire
